[sv/spq_pkg.sv]
// shared types, codes and defaults for the sorted priority queue
`default_nettype none

package spq_pkg;

    // default sizes handed to the top level parameters
    localparam int DEFAULT_CAPACITY      = 64;
    localparam int DEFAULT_ELEMENT_BITS  = 16;
    localparam int DEFAULT_PRIORITY_BITS = 16;

    // action codes
    localparam logic [2:0] ACT_INSERT      = 3'd0;
    localparam logic [2:0] ACT_REMOVE_HEAD = 3'd1;
    localparam logic [2:0] ACT_REMOVE      = 3'd2;
    localparam logic [2:0] ACT_CHANGE      = 3'd3;
    localparam logic [2:0] ACT_CONTAINS    = 3'd4;
    localparam logic [2:0] ACT_CLEAR       = 3'd5;
    localparam logic [2:0] ACT_ITER_FIRST  = 3'd6;
    localparam logic [2:0] ACT_ITER_NEXT   = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_END       = 2'd3;

    // request transfer
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] element_id;
        logic [15:0] priority_req;
        logic [15:0] match_priority;
    } t_in_item;

    // result transfer
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] element_out;
        logic [15:0] priority_out;
        logic [6:0]  entry_count;
    } t_out_item;

endpackage

`default_nettype wire

[sv/spq_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic                                    i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/sorted_priority_queue_unit.sv]
// sorted priority queue: table walker sequencer over one ram
//
// Usage: requests come in on the i_in_* channel (valid/stall), one action per
// transfer; every request yields exactly one result transfer on o_out_*.
// Entries are kept in descending priority, equal priorities in arrival order.
// The table lives in one ram; a single sequencer walks it one entry per
// cycle through the ram read port, with one shared compare unit, shifting
// entries as it goes. o_in_stall is high from the cycle after a request is
// taken until its result is loaded into the output register.
// Clear, insert into a full table, remove head when empty and iterate go
// straight to the result; insert walks the table backward, remove head, remove
// and contains walk it forward, and change priority walks forward, then back.
// One request at a time: the next one is taken the cycle after the result is
// loaded; a new request is taken while that result still waits in the output
// register, and its own result waits in the sequencer until the register frees.
// Reset empties the queue and the cursor at once; the ram is not cleared,
// since only entries below the count are ever read.
// When the receiver stalls, the result holds on o_out_data unchanged.
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int CAPACITY      = spq_pkg::DEFAULT_CAPACITY,
    parameter int ELEMENT_BITS  = spq_pkg::DEFAULT_ELEMENT_BITS,
    parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire spq_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output spq_pkg::t_out_item     o_out_data
);

    localparam int EB = ELEMENT_BITS;
    localparam int PB = PRIORITY_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_RESULT
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_occ, n_occ;
    logic [AW-1:0]      r_cur, n_cur;
    logic               r_cur_valid, n_cur_valid;
    logic [2:0]         r_action, n_action;
    logic [EB-1:0]      r_el, n_el;
    logic [PB-1:0]      r_pr, n_pr;
    logic [PB-1:0]      r_oldp, n_oldp;
    logic [CW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_didx, n_didx;
    logic               r_pend, n_pend;
    logic               r_hit, n_hit;
    logic [1:0]         r_status, n_status;
    logic               r_found, n_found;
    logic               r_out_valid, n_out_valid;
    spq_pkg::t_out_item r_out, n_out;

    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [EB+PB-1:0]   w_wr_data;
    logic [EB+PB-1:0]   w_rd_data;
    logic [EB-1:0]      w_rd_el;
    logic [PB-1:0]      w_rd_pr;
    logic               w_el_eq;
    logic               w_pr_eq;
    logic               w_pr_ge;
    logic               w_match;
    logic               w_iter;
    logic [CW-1:0]      w_idx_m1;
    logic [CW-1:0]      w_idx_m2;

    // table storage, element in the upper bits, priority in the lower
    spq_ram #(
        .WIDTH(EB + PB),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_rd_el = w_rd_data[EB+PB-1:PB];
    assign w_rd_pr = w_rd_data[PB-1:0];

    // shared compare unit on the entry coming out of the ram
    assign w_el_eq = (w_rd_el == r_el);
    assign w_pr_eq = (w_rd_pr == r_oldp);
    assign w_pr_ge = (w_rd_pr >= r_pr);
    assign w_match = (r_action == spq_pkg::ACT_REMOVE_HEAD) ||
                     (w_el_eq && ((r_action != spq_pkg::ACT_CHANGE) || w_pr_eq));
    assign w_iter  = (r_action == spq_pkg::ACT_ITER_FIRST) ||
                     (r_action == spq_pkg::ACT_ITER_NEXT);

    assign w_idx_m1 = r_idx - CW'(1);
    assign w_idx_m2 = r_idx - CW'(2);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_action    = r_action;
        n_el        = r_el;
        n_pr        = r_pr;
        n_oldp      = r_oldp;
        n_idx       = r_idx;
        n_didx      = r_didx;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_status    = r_status;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_wr_data   = '0;

        // output register drains on a transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_in_data.action;
                    n_el     = EB'(i_in_data.element_id);
                    n_pr     = PB'(i_in_data.priority_req);
                    n_oldp   = PB'(i_in_data.match_priority);
                    n_status = spq_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                    unique case (i_in_data.action) inside
                        spq_pkg::ACT_INSERT: begin
                            n_cur_valid = 1'b0;
                            if (r_occ >= CW'(CAPACITY)) begin
                                n_status = spq_pkg::ST_FULL;
                                n_state  = S_RESULT;
                            end else begin
                                n_idx   = r_occ;
                                n_state = S_INS;
                            end
                        end
                        spq_pkg::ACT_REMOVE_HEAD: begin
                            n_cur_valid = 1'b0;
                            if (r_occ == '0) begin
                                n_status = spq_pkg::ST_END;
                                n_state  = S_RESULT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        spq_pkg::ACT_REMOVE, spq_pkg::ACT_CHANGE: begin
                            n_cur_valid = 1'b0;
                            n_state     = S_SCAN;
                        end
                        spq_pkg::ACT_CONTAINS: begin
                            n_state = S_SCAN;
                        end
                        spq_pkg::ACT_CLEAR: begin
                            n_occ       = '0;
                            n_cur_valid = 1'b0;
                            n_state     = S_RESULT;
                        end
                        spq_pkg::ACT_ITER_FIRST: begin
                            if (r_occ == '0) begin
                                n_cur_valid = 1'b0;
                                n_status    = spq_pkg::ST_END;
                            end else begin
                                n_cur       = '0;
                                n_cur_valid = 1'b1;
                                w_rd_en     = 1'b1;
                                w_rd_addr   = '0;
                            end
                            n_state = S_RESULT;
                        end
                        spq_pkg::ACT_ITER_NEXT: begin
                            if (r_cur_valid && ((CW'(r_cur) + CW'(1)) < r_occ)) begin
                                n_cur     = r_cur + AW'(1);
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_cur + AW'(1);
                            end else begin
                                n_cur_valid = 1'b0;
                                n_status    = spq_pkg::ST_END;
                            end
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end

            // forward walk: find the first match, then pull later entries down
            S_SCAN: begin
                if (r_idx < r_occ) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_didx    = r_idx[AW-1:0];
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_hit) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_didx - AW'(1);
                        w_wr_data = w_rd_data;
                    end else if (w_match) begin
                        if (r_action == spq_pkg::ACT_CONTAINS) begin
                            n_found  = 1'b1;
                            n_status = spq_pkg::ST_OK;
                            n_state  = S_RESULT;
                        end else begin
                            n_hit = 1'b1;
                        end
                    end
                end else if (r_idx >= r_occ) begin
                    if (!r_hit) begin
                        n_status = spq_pkg::ST_NOT_FOUND;
                        n_state  = S_RESULT;
                    end else begin
                        n_occ = r_occ - CW'(1);
                        if (r_action == spq_pkg::ACT_CHANGE) begin
                            n_idx   = r_occ - CW'(1);
                            n_pend  = 1'b0;
                            n_state = S_INS;
                        end else begin
                            n_state = S_RESULT;
                        end
                    end
                end
            end

            // backward walk: shift lower priorities up, drop the new entry in
            S_INS: begin
                if (!r_pend) begin
                    if (r_idx == '0) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = {r_el, r_pr};
                        n_occ     = r_occ + CW'(1);
                        n_status  = spq_pkg::ST_OK;
                        n_state   = S_RESULT;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_idx_m1[AW-1:0];
                        n_pend    = 1'b1;
                    end
                end else if (w_pr_ge) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx[AW-1:0];
                    w_wr_data = {r_el, r_pr};
                    n_occ     = r_occ + CW'(1);
                    n_status  = spq_pkg::ST_OK;
                    n_pend    = 1'b0;
                    n_state   = S_RESULT;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx[AW-1:0];
                    w_wr_data = w_rd_data;
                    n_idx     = w_idx_m1;
                    if (w_idx_m1 == '0) begin
                        n_pend = 1'b0;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_idx_m2[AW-1:0];
                        n_pend    = 1'b1;
                    end
                end
            end

            // load the output register once it is free
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_status;
                    n_out.found        = r_found;
                    n_out.element_out  = (w_iter && (r_status == spq_pkg::ST_OK)) ?
                                         16'(w_rd_el) : 16'd0;
                    n_out.priority_out = (w_iter && (r_status == spq_pkg::ST_OK)) ?
                                         16'(w_rd_pr) : 16'd0;
                    n_out.entry_count  = 7'(r_occ);
                    n_state            = S_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_action    <= n_action;
            r_el        <= n_el;
            r_pr        <= n_pr;
            r_oldp      <= n_oldp;
            r_idx       <= n_idx;
            r_didx      <= n_didx;
            r_pend      <= n_pend;
            r_hit       <= n_hit;
            r_status    <= n_status;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

endmodule

`default_nettype wire

[sv/spq_checker.sv]
// port level checks for the sorted priority queue, bound to the top level
`default_nettype none

module spq_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire spq_pkg::t_out_item o_out_data
);

    // a stalled result stays valid
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // each request transfer leaves the sequencer busy in the cycle after it is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while sequencer idle next cycle");

    // found only comes with success
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> (o_out_data.status == spq_pkg::ST_OK))
        else $error("found flag with failing status");

    // failing results carry no element or priority
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != spq_pkg::ST_OK)) |->
        ((o_out_data.element_out == 16'd0) && (o_out_data.priority_out == 16'd0)))
        else $error("failing result with nonzero element or priority");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

`default_nettype wire

[tb/sorted_priority_queue_check.sv]
// transfer monitor and result checker for the sorted priority queue
module sorted_priority_queue_check (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire spq_pkg::t_in_item  i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire spq_pkg::t_out_item i_out_data,
    output int unsigned             o_error_count,
    output int unsigned             o_pending,
    output int unsigned             o_checked,
    output int unsigned             o_full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = spq_pkg::DEFAULT_CAPACITY;

    typedef struct packed {
        logic [15:0] el;
        logic [15:0] pr;
    } t_entry;

    // shadow of the sorted table, head first
    t_entry             table_rows[$];
    int                 cursor_at;
    bit                 cursor_ok;
    spq_pkg::t_out_item expected_results[$];
    spq_pkg::t_out_item oldest;
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        full_seen;

    // new entry goes behind every entry of greater or equal priority
    function automatic void insert_sorted(input logic [15:0] el, input logic [15:0] pr);
        int pos;
        t_entry row;
        pos = 0;
        while (pos < table_rows.size() && table_rows[pos].pr >= pr)
            pos++;
        row.el = el;
        row.pr = pr;
        table_rows.insert(pos, row);
    endfunction

    // carry out one request on the shadow table and return its result
    function automatic spq_pkg::t_out_item apply_action(input spq_pkg::t_in_item req);
        spq_pkg::t_out_item res;
        int pos;
        res = '0;
        res.status = spq_pkg::ST_OK;
        case (req.action) inside
            spq_pkg::ACT_INSERT: begin
                cursor_ok = 1'b0;
                if (table_rows.size() >= CAPACITY)
                    res.status = spq_pkg::ST_FULL;
                else
                    insert_sorted(req.element_id, req.priority_req);
            end
            spq_pkg::ACT_REMOVE_HEAD: begin
                cursor_ok = 1'b0;
                if (table_rows.size() == 0)
                    res.status = spq_pkg::ST_END;
                else
                    table_rows.delete(0);
            end
            spq_pkg::ACT_REMOVE, spq_pkg::ACT_CHANGE: begin
                cursor_ok = 1'b0;
                pos = -1;
                for (int i = 0; i < table_rows.size(); i++) begin
                    if (table_rows[i].el == req.element_id &&
                        (req.action == spq_pkg::ACT_REMOVE ||
                         table_rows[i].pr == req.match_priority)) begin
                        pos = i;
                        break;
                    end
                end
                if (pos < 0) begin
                    res.status = spq_pkg::ST_NOT_FOUND;
                end else begin
                    table_rows.delete(pos);
                    if (req.action == spq_pkg::ACT_CHANGE)
                        insert_sorted(req.element_id, req.priority_req);
                end
            end
            spq_pkg::ACT_CONTAINS: begin
                res.status = spq_pkg::ST_NOT_FOUND;
                for (int i = 0; i < table_rows.size(); i++) begin
                    if (table_rows[i].el == req.element_id) begin
                        res.status = spq_pkg::ST_OK;
                        res.found = 1'b1;
                        break;
                    end
                end
            end
            spq_pkg::ACT_CLEAR: begin
                table_rows.delete();
                cursor_ok = 1'b0;
            end
            spq_pkg::ACT_ITER_FIRST: begin
                if (table_rows.size() == 0) begin
                    cursor_ok = 1'b0;
                    res.status = spq_pkg::ST_END;
                end else begin
                    cursor_at = 0;
                    cursor_ok = 1'b1;
                end
            end
            default: begin
                if (cursor_ok && cursor_at + 1 < table_rows.size()) begin
                    cursor_at++;
                end else begin
                    cursor_ok = 1'b0;
                    res.status = spq_pkg::ST_END;
                end
            end
        endcase
        // iteration reports the entry under the cursor
        if ((req.action == spq_pkg::ACT_ITER_FIRST ||
             req.action == spq_pkg::ACT_ITER_NEXT) &&
            res.status == spq_pkg::ST_OK) begin
            res.element_out  = table_rows[cursor_at].el;
            res.priority_out = table_rows[cursor_at].pr;
        end
        res.entry_count = 7'(table_rows.size());
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            mismatches++;
        end
    endtask

    // watch both channels; results are checked before the request of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_rows.delete();
            expected_results.delete();
            cursor_at = 0;
            cursor_ok = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: 0x%0h", i_out_data);
                    mismatches++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("status", oldest.status, i_out_data.status);
                    check_field("found", oldest.found, i_out_data.found);
                    check_field("element_out", oldest.element_out, i_out_data.element_out);
                    check_field("priority_out", oldest.priority_out,
                                i_out_data.priority_out);
                    check_field("entry_count", oldest.entry_count, i_out_data.entry_count);
                    checked++;
                    if (oldest.status == spq_pkg::ST_FULL)
                        full_seen++;
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_action(i_in_data));
        end
        o_pending     <= expected_results.size();
        o_error_count <= mismatches;
        o_checked     <= checked;
        o_full_seen   <= full_seen;
    end

endmodule

[tb/sorted_priority_queue_unit_test.sv]
// stimulus and verdict for the sorted priority queue unit
module sorted_priority_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 160;
    localparam int BLOCK_ITEMS  = 110;
    localparam int POOL_DEPTH   = 16;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    spq_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    spq_pkg::t_out_item o_out_data;

    int unsigned error_count;
    int unsigned pending_results;
    int unsigned results_checked;
    int unsigned full_reports;

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          long_hold_wanted = 1'b0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;

    // recently inserted pairs, so removes and changes often hit
    logic [15:0] recent_el [POOL_DEPTH];
    logic [15:0] recent_pr [POOL_DEPTH];
    int          recent_n  = 0;
    int          recent_wr = 0;

    sorted_priority_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    sorted_priority_queue_check result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_error_count (error_count),
        .o_pending     (pending_results),
        .o_checked     (results_checked),
        .o_full_seen   (full_reports)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // receiver: random stalls, or one long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_wanted) begin
                long_hold_wanted = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic spq_pkg::t_in_item make_req(input logic [2:0] action,
                                                   input logic [15:0] el,
                                                   input logic [15:0] pr,
                                                   input logic [15:0] oldp);
        spq_pkg::t_in_item req;
        req.action         = action;
        req.element_id     = el;
        req.priority_req   = pr;
        req.match_priority = oldp;
        return req;
    endfunction

    // random request; grow_pct sets the share of inserts
    function automatic spq_pkg::t_in_item random_request(input int grow_pct);
        spq_pkg::t_in_item req;
        int r;
        int pick;
        req = '0;
        req.match_priority = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < grow_pct) begin
            req.action = spq_pkg::ACT_INSERT;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 15)      req.action = spq_pkg::ACT_REMOVE_HEAD;
            else if (r < 30) req.action = spq_pkg::ACT_REMOVE;
            else if (r < 48) req.action = spq_pkg::ACT_CHANGE;
            else if (r < 63) req.action = spq_pkg::ACT_CONTAINS;
            else if (r < 65) req.action = spq_pkg::ACT_CLEAR;
            else if (r < 75) req.action = spq_pkg::ACT_ITER_FIRST;
            else             req.action = spq_pkg::ACT_ITER_NEXT;
        end
        pick = (recent_n > 0) ? $urandom_range(0, recent_n - 1) : 0;
        // element: mostly small or recently used ids, sometimes anything
        case ($urandom_range(0, 9))
            0:       req.element_id = 16'($urandom);
            1:       req.element_id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2, 3, 4: req.element_id = 16'($urandom_range(0, 15));
            default: req.element_id = (recent_n > 0) ? recent_el[pick]
                                                     : 16'($urandom_range(0, 15));
        endcase
        // priority: ties are common on purpose
        case ($urandom_range(0, 9))
            0, 1, 2: req.priority_req = 16'($urandom);
            3:       req.priority_req = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            4, 5, 6: req.priority_req = 16'($urandom_range(0, 3));
            default: req.priority_req = (recent_n > 0)
                                        ? recent_pr[$urandom_range(0, recent_n - 1)]
                                        : 16'($urandom_range(0, 3));
        endcase
        // change priority usually names a pair that was inserted
        if (req.action == spq_pkg::ACT_CHANGE && recent_n > 0 &&
            $urandom_range(0, 9) < 7) begin
            req.element_id     = recent_el[pick];
            req.match_priority = recent_pr[pick];
            recent_pr[pick]    = req.priority_req;
        end
        if (req.action == spq_pkg::ACT_INSERT) begin
            recent_el[recent_wr] = req.element_id;
            recent_pr[recent_wr] = req.priority_req;
            recent_wr = (recent_wr + 1) % POOL_DEPTH;
            if (recent_n < POOL_DEPTH)
                recent_n++;
        end
        return req;
    endfunction

    // offer one request, with random idle cycles first, until it is taken
    task automatic push_request(input spq_pkg::t_in_item req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // stop sending until every outstanding result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results != 0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table corner cases
        push_request(make_req(spq_pkg::ACT_REMOVE_HEAD, 16'h0000, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        push_request(make_req(spq_pkg::ACT_CHANGE, 16'h0000, 16'h0001, 16'h0000));
        push_request(make_req(spq_pkg::ACT_CONTAINS, 16'h0000, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_ITER_FIRST, 16'h0000, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_ITER_NEXT, 16'h0000, 16'h0000, 16'h0000));

        // field extremes, equal priorities and a duplicate element
        push_request(make_req(spq_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000));
        push_request(make_req(spq_pkg::ACT_INSERT, 16'h0000, 16'h0000, 16'hFFFF));
        push_request(make_req(spq_pkg::ACT_INSERT, 16'h1234, 16'h8000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_INSERT, 16'h5678, 16'h8000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_INSERT, 16'h1234, 16'h0001, 16'h0000));

        // any change drops the cursor
        push_request(make_req(spq_pkg::ACT_ITER_FIRST, 16'h0000, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_ITER_NEXT, 16'h0000, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_INSERT, 16'h00FF, 16'h7FFF, 16'h0000));
        push_request(make_req(spq_pkg::ACT_ITER_NEXT, 16'h0000, 16'h0000, 16'h0000));

        // full walk and one step past the end
        push_request(make_req(spq_pkg::ACT_ITER_FIRST, 16'h0000, 16'h0000, 16'h0000));
        for (int k = 0; k < 6; k++)
            push_request(make_req(spq_pkg::ACT_ITER_NEXT, 16'h0000, 16'h0000, 16'h0000));

        // contains, change with wrong and right old priority, first-match remove
        push_request(make_req(spq_pkg::ACT_CONTAINS, 16'h1234, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_CHANGE, 16'h1234, 16'h8000, 16'h0002));
        push_request(make_req(spq_pkg::ACT_CHANGE, 16'h1234, 16'h8000, 16'h0001));
        push_request(make_req(spq_pkg::ACT_REMOVE, 16'h1234, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        push_request(make_req(spq_pkg::ACT_INSERT, 16'h4321, 16'h0042, 16'h0000));
        wait_for_results();

        // random traffic: grow to full, mixed, then shrink, in four handshake phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 55; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            for (int blk = 0; blk < 3; blk++) begin
                if (phase == 0 && blk == 1)
                    long_hold_wanted = 1'b1;
                for (int n = 0; n < BLOCK_ITEMS; n++)
                    push_request(random_request(blk == 0 ? 80 : (blk == 1 ? 45 : 15)));
            end
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d requests over four handshake phases and one long output hold",
                 items_sent);
        $display("%0d results compared, %0d of them reporting a full table",
                 results_checked, full_reports);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
